/* hdl/ffba_pkg.sv */
// Shared types and constants of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int FUNC_W = 2;
    localparam int SIZE_W = 12;
    localparam int OFF_W  = 12;

    localparam int ARENA_BYTES_DEF  = 4096;
    localparam int HEADER_BYTES_DEF = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic {
        ALU_ADD,   // a + b + header bytes
        ALU_SUB    // a - b, ge flag = a >= b
    } alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_CMP,
        ST_A_FIT,
        ST_A_NEXT,
        ST_A_REST,
        ST_A_SPLIT,
        ST_A_APP,
        ST_A_CHK,
        ST_F_RD,
        ST_F_WR,
        ST_M_CMP,
        ST_M_EVAL,
        ST_M_NEXT,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

/* hdl/ffba_req_if.sv */
// Request channel of the allocator: valid/ready plus request fields.
`default_nettype none
interface ffba_req_if;
    logic                       valid;
    logic                       ready;
    logic [ffba_pkg::FUNC_W-1:0] func;
    logic [ffba_pkg::SIZE_W-1:0] request_size;
    logic [ffba_pkg::OFF_W-1:0]  block_offset;

    modport source (output valid, output func, output request_size, output block_offset,
                    input ready);
    modport sink   (input valid, input func, input request_size, input block_offset,
                    output ready);
endinterface
`default_nettype wire

/* hdl/ffba_rsp_if.sv */
// Response channel of the allocator: valid/ready plus result fields.
`default_nettype none
interface ffba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ffba_pkg::OFF_W-1:0]  result_offset;
    logic                       status;

    modport source (output valid, output result_offset, output status, input ready);
    modport sink   (input valid, input result_offset, input status, output ready);
endinterface
`default_nettype wire

/* hdl/ffba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* hdl/ffba_alu.sv */
// Shared adder of the allocator: next-header add and compare-by-subtract.
`default_nettype none
module ffba_alu #(
    parameter int EW           = 14,
    parameter int HEADER_BYTES = 16
) (
    input  wire ffba_pkg::alu_op_t op,
    input  wire logic [EW-1:0]     a,
    input  wire logic [EW-1:0]     b,
    output logic      [EW-1:0]     y,
    output logic                   ge
);
    import ffba_pkg::*;

    logic [EW:0] opb;
    logic [EW:0] cin;
    logic [EW:0] sum;

    always_comb
    begin
        unique case (op)
            ALU_ADD:
            begin
                opb = {1'b0, b};
                cin = (EW+1)'(HEADER_BYTES);
            end
            ALU_SUB:
            begin
                opb = {1'b0, ~b};
                cin = (EW+1)'(1);
            end
            default:
            begin
                opb = '0;
                cin = '0;
            end
        endcase
        sum = {1'b0, a} + opb + cin;
    end

    assign y  = sum[EW-1:0];
    assign ge = sum[EW];   // no borrow on subtract

endmodule
`default_nettype wire

/* hdl/first_fit_block_allocator.sv */
// First-fit block allocator over a byte arena held as an implicit block list.
//
// req channel (valid/ready) takes one item: func selects allocate, free or
// release-all; request_size is the payload wanted by an allocate and
// block_offset the header offset to free. rsp channel returns exactly one
// item per request: result_offset (header offset of the new block, else 0)
// and status (1 when the arena has no room for the allocation).
// One request is worked on at a time; req.ready is high only while idle.
// Per block visited, the list walk steps through a compare, a header check
// and a next-header add. An allocate ends on a fit, a fit and split, or an
// append that may find the arena out of space; a free clears the used flag
// and then walks the whole list for merging; release-all goes straight to
// the result, as an unused func does.
// Each block costs one header read through the single read port of the
// header RAM, and the sequencer shares one adder across its steps.
// A finished result sits in an output register; the next request is taken
// while it waits, and a result behind it holds until rsp.ready frees it.
// Reset clears the heap top, the sequencer and the output valid. The
// header RAM is not cleared; the walk only reaches headers written since.
`default_nettype none
module first_fit_block_allocator #(
    parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp
);
    import ffba_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int EW = ((AW > OFF_W) ? AW : OFF_W) + 2;

    state_t state_reg, state_next;

    logic [EW-1:0]    cur_reg, cur_next;
    logic [AW:0]      top_reg, top_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [AW-1:0]    sz_reg, sz_next;
    logic [AW-1:0]    headsz_reg, headsz_next;
    logic [EW-1:0]    val_reg, val_next;
    logic             in_run_reg, in_run_next;
    logic [SIZE_W-1:0] reqsz_reg, reqsz_next;
    logic [OFF_W-1:0] boff_reg, boff_next;
    logic [AW-1:0]    res_off_reg, res_off_next;
    logic             res_stat_reg, res_stat_next;
    logic             out_valid_reg, out_valid_next;
    logic [OFF_W-1:0] out_off_reg, out_off_next;
    logic             out_stat_reg, out_stat_next;

    alu_op_t          alu_op;
    logic [EW-1:0]    alu_a, alu_b, alu_y;
    logic             alu_ge;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [AW:0]      ram_wdata, ram_rdata;
    logic             rd_used;
    logic [AW-1:0]    rd_size;

    logic [EW-1:0]    req_ext, boff_ext, top_ext, arena_ext, hdr_ext;

    assign rd_used   = ram_rdata[AW];
    assign rd_size   = ram_rdata[AW-1:0];
    assign req_ext   = EW'(reqsz_reg);
    assign boff_ext  = EW'(boff_reg);
    assign top_ext   = EW'(top_reg);
    assign arena_ext = EW'(ARENA_BYTES);
    assign hdr_ext   = EW'(HEADER_BYTES);

    ffba_alu #(
        .EW           (EW),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y),
        .ge (alu_ge)
    );

    ffba_ram #(
        .WIDTH (AW + 1),
        .DEPTH (ARENA_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.result_offset = out_off_reg;
    assign rsp.status        = out_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
            in_run_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            out_valid_reg <= out_valid_next;
            in_run_reg    <= in_run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        head_reg     <= head_next;
        sz_reg       <= sz_next;
        headsz_reg   <= headsz_next;
        val_reg      <= val_next;
        reqsz_reg    <= reqsz_next;
        boff_reg     <= boff_next;
        res_off_reg  <= res_off_next;
        res_stat_reg <= res_stat_next;
        out_off_reg  <= out_off_next;
        out_stat_reg <= out_stat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        top_next       = top_reg;
        head_next      = head_reg;
        sz_next        = sz_reg;
        headsz_next    = headsz_reg;
        val_next       = val_reg;
        in_run_next    = in_run_reg;
        reqsz_next     = reqsz_reg;
        boff_next      = boff_reg;
        res_off_next   = res_off_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_off_next   = out_off_reg;
        out_stat_next  = out_stat_reg;

        alu_op    = ALU_SUB;
        alu_a     = cur_reg;
        alu_b     = top_ext;
        ram_we    = 1'b0;
        ram_waddr = cur_reg[AW-1:0];
        ram_wdata = '0;
        ram_raddr = cur_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    reqsz_next    = req.request_size;
                    boff_next     = req.block_offset;
                    cur_next      = '0;
                    res_off_next  = '0;
                    res_stat_next = 1'b0;
                    unique case (req.func)
                        FUNC_ALLOC:   state_next = ST_A_CMP;
                        FUNC_FREE:    state_next = ST_F_RD;
                        FUNC_RELEASE:
                        begin
                            top_next   = '0;
                            state_next = ST_DONE;
                        end
                        default:      state_next = ST_DONE;
                    endcase
                end
            end

            // allocate: walk list while cur < top
            ST_A_CMP:
            begin
                state_next = alu_ge ? ST_A_APP : ST_A_FIT;
            end
            ST_A_FIT:
            begin
                alu_a   = EW'(rd_size);
                alu_b   = req_ext;
                sz_next = rd_size;
                if (!rd_used && alu_ge)
                begin
                    val_next   = alu_y;
                    state_next = ST_A_REST;
                end
                else
                begin
                    state_next = ST_A_NEXT;
                end
            end
            ST_A_NEXT:
            begin
                alu_op     = ALU_ADD;
                alu_b      = EW'(sz_reg);
                cur_next   = alu_y;
                state_next = ST_A_CMP;
            end
            ST_A_REST:
            begin
                alu_a  = val_reg;
                alu_b  = hdr_ext;
                ram_we = 1'b1;
                if (alu_ge && (alu_y != '0))
                begin
                    ram_wdata  = {1'b1, AW'(reqsz_reg)};
                    val_next   = alu_y;
                    state_next = ST_A_SPLIT;
                end
                else
                begin
                    ram_wdata    = {1'b1, sz_reg};
                    res_off_next = cur_reg[AW-1:0];
                    state_next   = ST_DONE;
                end
            end
            ST_A_SPLIT:
            begin
                alu_op       = ALU_ADD;
                alu_b        = req_ext;
                ram_we       = (alu_y < arena_ext);
                ram_waddr    = alu_y[AW-1:0];
                ram_wdata    = {1'b0, val_reg[AW-1:0]};
                res_off_next = cur_reg[AW-1:0];
                state_next   = ST_DONE;
            end
            ST_A_APP:
            begin
                alu_op     = ALU_ADD;
                alu_a      = top_ext;
                alu_b      = req_ext;
                val_next   = alu_y;
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                alu_a = arena_ext;
                alu_b = val_reg;
                if (alu_ge)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = top_reg[AW-1:0];
                    ram_wdata    = {1'b1, AW'(reqsz_reg)};
                    res_off_next = top_reg[AW-1:0];
                    top_next     = val_reg[AW:0];
                end
                else
                begin
                    res_stat_next = 1'b1;
                end
                state_next = ST_DONE;
            end

            // free: clear used flag, then merge walk
            ST_F_RD:
            begin
                alu_a       = boff_ext;
                alu_b       = arena_ext;
                ram_raddr   = boff_ext[AW-1:0];
                in_run_next = !alu_ge;
                state_next  = ST_F_WR;
            end
            ST_F_WR:
            begin
                ram_we      = in_run_reg;
                ram_waddr   = boff_ext[AW-1:0];
                ram_wdata   = {1'b0, rd_size};
                in_run_next = 1'b0;
                cur_next    = '0;
                state_next  = ST_M_CMP;
            end
            ST_M_CMP:
            begin
                state_next = alu_ge ? ST_DONE : ST_M_EVAL;
            end
            ST_M_EVAL:
            begin
                alu_op  = ALU_ADD;
                alu_a   = EW'(headsz_reg);
                alu_b   = EW'(rd_size);
                sz_next = rd_size;
                if (rd_used)
                begin
                    in_run_next = 1'b0;
                end
                else if (in_run_reg)
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = head_reg;
                    ram_wdata   = {1'b0, alu_y[AW-1:0]};
                    headsz_next = alu_y[AW-1:0];
                end
                else
                begin
                    head_next   = cur_reg[AW-1:0];
                    headsz_next = rd_size;
                    in_run_next = 1'b1;
                end
                state_next = ST_M_NEXT;
            end
            ST_M_NEXT:
            begin
                alu_op     = ALU_ADD;
                alu_b      = EW'(sz_reg);
                cur_next   = alu_y;
                state_next = ST_M_CMP;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = OFF_W'(res_off_reg);
                    out_stat_next  = res_stat_reg;
                    in_run_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for first_fit_block_allocator: random allocate/free/release traffic checked against an arena model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int ARENA  = ARENA_BYTES_DEF;
    localparam int HDR    = HEADER_BYTES_DEF;
    localparam int N_ITEMS = 1800;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  block_offset;
    } alloc_req_t;

    typedef struct packed {
        logic [OFF_W-1:0] result_offset;
        logic             status;
    } alloc_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              req_valid  = 1'b0;
    logic [FUNC_W-1:0] req_func   = '0;
    logic [SIZE_W-1:0] req_size   = '0;
    logic [OFF_W-1:0]  req_offset = '0;
    logic              rsp_ready  = 1'b0;
    logic              req_taken  = 1'b0;
    logic              rsp_hold   = 1'b0;

    int send_idle = 27;
    int recv_idle = 78;
    int n_gen = 0;
    int n_fail = 0;

    alloc_req_t pending_req [$];
    alloc_rsp_t pending_rsp [$];

    // arena image: per-offset header contents and which offsets were ever written
    int blk_size    [ARENA];
    bit blk_used    [ARENA];
    bit blk_written [ARENA];
    int heap_end = 0;
    int written_offs [$];

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    assign req_ch.valid        = req_valid;
    assign req_ch.func         = req_func;
    assign req_ch.request_size = req_size;
    assign req_ch.block_offset = req_offset;
    assign rsp_ch.ready        = rsp_ready;

    first_fit_block_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #2 clk = ~clk;

    function automatic void write_header(int off, int sz, bit used);
        blk_size[off] = sz;
        blk_used[off] = used;
        if (!blk_written[off])
        begin
            blk_written[off] = 1'b1;
            written_offs.push_back(off);
        end
    endfunction

    function automatic alloc_rsp_t step_arena(alloc_req_t r);
        alloc_rsp_t res;
        int cur;
        int head;
        int rest;
        int nh;
        bit in_run;
        bit found;
        res = '0;
        cur = 0;
        case (r.func)
            FUNC_ALLOC:
            begin
                found = 1'b0;
                while (cur < heap_end && !found)
                begin
                    if (!blk_used[cur] && blk_size[cur] >= int'(r.request_size))
                    begin
                        rest = blk_size[cur] - int'(r.request_size);
                        if (rest > HDR)
                        begin
                            nh = cur + HDR + int'(r.request_size);
                            write_header(cur, int'(r.request_size), 1'b1);
                            if (nh < ARENA)
                                write_header(nh, rest - HDR, 1'b0);
                        end
                        else
                            blk_used[cur] = 1'b1;
                        res.result_offset = cur[OFF_W-1:0];
                        found = 1'b1;
                    end
                    else
                        cur = cur + HDR + blk_size[cur];
                end
                if (!found)
                begin
                    if (heap_end + HDR + int'(r.request_size) > ARENA)
                        res.status = 1'b1;
                    else
                    begin
                        write_header(heap_end, int'(r.request_size), 1'b1);
                        res.result_offset = heap_end[OFF_W-1:0];
                        heap_end = heap_end + HDR + int'(r.request_size);
                    end
                end
            end
            FUNC_FREE:
            begin
                if (int'(r.block_offset) < ARENA)
                    blk_used[r.block_offset] = 1'b0;
                // coalesce every run of free blocks into its first block
                head = 0;
                in_run = 1'b0;
                while (cur < heap_end)
                begin
                    rest = blk_size[cur];
                    if (!blk_used[cur])
                    begin
                        if (in_run)
                            blk_size[head] = blk_size[head] + rest + HDR;
                        else
                        begin
                            head = cur;
                            in_run = 1'b1;
                        end
                    end
                    else
                        in_run = 1'b0;
                    cur = cur + HDR + rest;
                end
            end
            FUNC_RELEASE:
                heap_end = 0;
            default: ;
        endcase
        return res;
    endfunction

    function automatic void queue_item(logic [FUNC_W-1:0] f, int sz, int off);
        alloc_req_t r;
        r.func = f;
        r.request_size = sz[SIZE_W-1:0];
        r.block_offset = off[OFF_W-1:0];
        pending_req.push_back(r);
        if (f != FUNC_UNUSED)
            n_gen++;
    endfunction

    // driver
    always @(negedge clk)
    begin
        alloc_req_t nxt;
        if (rst_n && (!req_valid || req_taken))
        begin
            if (pending_req.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                nxt = pending_req.pop_front();
                req_valid  <= 1'b1;
                req_func   <= nxt.func;
                req_size   <= nxt.request_size;
                req_offset <= nxt.block_offset;
            end
            else
                req_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle);

    // monitor: check results, then predict for newly accepted items
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        alloc_req_t got;
        req_taken <= req_ch.valid && req_ch.ready;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result: result_offset %0d status %0d",
                       rsp_ch.result_offset, rsp_ch.status);
                n_fail++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_ch.result_offset !== want.result_offset)
                begin
                    $error("result_offset: expected %0d, got %0d",
                           want.result_offset, rsp_ch.result_offset);
                    n_fail++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_fail++;
                end
            end
        end
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            got.func = req_ch.func;
            got.request_size = req_ch.request_size;
            got.block_offset = req_ch.block_offset;
            pending_rsp.push_back(step_arena(got));
        end
    end

    // long receiver stall while the sender keeps pushing
    initial
    begin
        wait (n_gen >= 1300);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (500) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int hdrs [$];
        int cur;
        int pick;
        int sz;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_item(FUNC_RELEASE, 4095, 4095);
        queue_item(FUNC_ALLOC, 0, 0);
        queue_item(FUNC_ALLOC, 4095, 0);
        queue_item(FUNC_ALLOC, 100, 0);
        queue_item(FUNC_ALLOC, 200, 0);
        queue_item(FUNC_FREE, 0, 16);
        queue_item(FUNC_ALLOC, 50, 0);
        queue_item(FUNC_ALLOC, 34, 0);
        queue_item(FUNC_FREE, 0, 132);
        queue_item(FUNC_FREE, 0, 82);
        queue_item(FUNC_UNUSED, 4095, 4095);
        queue_item(FUNC_RELEASE, 0, 0);
        queue_item(FUNC_ALLOC, 10, 4095);
        queue_item(FUNC_FREE, 4095, 16);   // stale header, not on the list
        queue_item(FUNC_RELEASE, 0, 0);
        queue_item(FUNC_ALLOC, 4080, 0);   // arena exactly full
        queue_item(FUNC_ALLOC, 0, 0);
        queue_item(FUNC_FREE, 0, 0);
        queue_item(FUNC_ALLOC, 4063, 0);   // split leaves a one-byte block
        queue_item(FUNC_FREE, 0, 0);
        queue_item(FUNC_ALLOC, 4064, 0);   // remainder too small to split
        queue_item(FUNC_FREE, 0, 4079);
        queue_item(FUNC_RELEASE, 0, 0);
        queue_item(FUNC_FREE, 0, 0);

        while (n_gen < N_ITEMS)
        begin
            while (pending_req.size() >= 2)
                @(posedge clk);
            if (n_gen >= 1200)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            else if (n_gen >= 600)
            begin
                send_idle = 78;
                recv_idle = 27;
            end
            if (n_gen == 900)
            begin
                while (pending_req.size() > 0 || req_valid || pending_rsp.size() > 0)
                    @(posedge clk);
            end
            pick = $urandom_range(99);
            if (pick < 3)
                queue_item(FUNC_UNUSED, $urandom_range(4095), $urandom_range(4095));
            else if (pick < 7)
                queue_item(FUNC_RELEASE, $urandom_range(4095), $urandom_range(4095));
            else if (pick < 40 && written_offs.size() > 0)
            begin
                hdrs.delete();
                cur = 0;
                while (cur < heap_end)
                begin
                    hdrs.push_back(cur);
                    cur = cur + HDR + blk_size[cur];
                end
                if (hdrs.size() > 0 && $urandom_range(99) < 85)
                    cur = hdrs[$urandom_range(hdrs.size() - 1)];
                else
                    cur = written_offs[$urandom_range(written_offs.size() - 1)];
                queue_item(FUNC_FREE, $urandom_range(4095), cur);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                    sz = $urandom_range(300);
                else if (pick < 90)
                    sz = $urandom_range(1200, 301);
                else if (pick < 97)
                    sz = $urandom_range(4080, 1201);
                else
                    sz = $urandom_range(4095, 4081);
                queue_item(FUNC_ALLOC, sz, $urandom_range(4095));
            end
        end

        while (pending_req.size() > 0 || req_valid)
            @(posedge clk);
        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (n_fail == 0 && pending_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
